FILE: design/ast_pkg.sv
// Package for the assignment statement tokenizer: token kind codes, the
// token record that the result queue holds, character constants and the
// character class functions. It depends on nothing else.
`default_nettype none

package ast_pkg;

    // Token kinds as they leave the block on the tuser lines.
    typedef enum logic [2:0] {
        KIND_KEYWORD = 3'd0,
        KIND_IDENT   = 3'd1,
        KIND_EQUALS  = 3'd2,
        KIND_SEMI    = 3'd3,
        KIND_INT     = 3'd4,
        KIND_ERROR   = 3'd5
    } token_kind_t;

    // One finished token as it waits in the result queue.
    typedef struct packed {
        token_kind_t  kind;
        logic [30:0]  value;
        logic [6:0]   length;
        logic [63:0]  head;
        logic         overflow;
        logic         last;
    } token_t;

    localparam logic [7:0]  CHAR_NUL        = 8'h00;
    localparam logic [7:0]  CHAR_EQUALS     = 8'h3D;
    localparam logic [7:0]  CHAR_SEMI       = 8'h3B;
    localparam logic [7:0]  CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0]  CHAR_SPACE      = 8'h20;
    localparam logic [7:0]  CHAR_TAB        = 8'h09;
    localparam logic [7:0]  CHAR_CR         = 8'h0D;
    localparam logic [7:0]  CHAR_DIGIT_0    = 8'h30;
    localparam logic [7:0]  CHAR_DIGIT_9    = 8'h39;
    localparam logic [7:0]  CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0]  CHAR_UPPER_Z    = 8'h5A;
    localparam logic [7:0]  CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0]  CHAR_LOWER_Z    = 8'h7A;

    // "int" packed with its first character in the low byte.
    localparam logic [63:0] KEYWORD_HEAD    = 64'h0000_0000_0074_6E69;
    localparam logic [30:0] INT_LIMIT       = 31'h7FFF_FFFF;

    function automatic logic is_letter(input logic [7:0] c);
        return (c == CHAR_UNDERSCORE)
            || (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9);
    endfunction

    // Space, and tab through carriage return (tab, newline, vertical tab,
    // form feed, carriage return).
    function automatic logic is_space(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

endpackage

`default_nettype wire

FILE: design/assignment_statement_tokenizer.sv
// Top level of the assignment statement tokenizer: character stream in,
// token stream out through a four-entry result queue.
// Depends on ast_pkg for token kinds, the token record and character classes.
//
// Usage
// -----
// Characters arrive one per beat on the slave stream (s_axis_*), tdata holding
// the ASCII code. Tokens leave on the master stream (m_axis_*): tuser carries
// the token kind, tdata the value, identifier length, first eight identifier
// characters and the overflow flag, and tlast marks the final token that one
// character causes. A character code of zero flushes a pending token.
//
// Latency and throughput: every accepted character is decoded in the cycle it
// arrives, and any token it finishes is registered into the result queue. A new
// character can be taken every cycle while s_axis_tready is high, i.e. while at
// least two queue entries are free. A character that both ends a pending token
// and stands for one itself writes two queue entries at once; the queue drains
// one token per cycle unless stalled, so the sustained rate is one character
// per cycle as long as tokens on average leave as fast as they are made.
//
// When the receiver stalls, tokens wait in the queue unchanged and the input
// side carries on until fewer than two entries remain free. Reset empties the
// queue and leaves no token pending.
`default_nettype none

module assignment_statement_tokenizer #(
    parameter int MAX_TOKEN_LEN = 64
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] char_code

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [30:0] token_value, [37:31] ident_length, [101:38] ident_head,
    // [102] overflow_flag, [103] zero fill
    output logic [103:0]      m_axis_tdata,
    output logic [2:0]        m_axis_tuser,   // [2:0] token_kind
    output logic              m_axis_tlast    // last_of_run
);

    import ast_pkg::*;

    // Identifier length counter is wide enough to hold MAX_TOKEN_LEN itself.
    localparam int LEN_W  = $clog2(MAX_TOKEN_LEN + 1);
    localparam int Q_DEPTH = 4;
    localparam int QPTR_W = $clog2(Q_DEPTH);
    localparam int QCNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_START,
        MODE_INT,
        MODE_IDENT
    } scan_mode_t;

    // Scanner state.
    scan_mode_t          mode_reg,  mode_next;
    logic [LEN_W-1:0]    len_reg,   len_next;
    logic [30:0]         acc_reg,   acc_next;
    logic [63:0]         head_reg,  head_next;
    logic                ovf_reg,   ovf_next;

    // Result queue: the oldest token always sits in entry zero.
    token_t              q_reg [Q_DEPTH];
    token_t              q_next [Q_DEPTH];
    logic [QCNT_W-1:0]   count_reg,  count_next;
    logic [QPTR_W-1:0]   wr_idx;

    logic                in_beat;
    logic                out_beat;
    logic [7:0]          c;
    logic                c_letter;
    logic                c_digit;
    logic [34:0]         acc_times_ten;
    logic                pend_valid;
    logic                char_valid;
    token_t              pend_tok;
    token_t              char_tok;
    token_t              first_tok;
    logic [1:0]          push_count;
    token_t              head_tok;

    assign c        = s_axis_tdata;
    assign c_letter = is_letter(c);
    assign c_digit  = is_digit(c);

    // Room for the worst case of two tokens from one character.
    assign s_axis_tready = (count_reg <= QCNT_W'(Q_DEPTH - 2));
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != '0);
    assign out_beat      = m_axis_tvalid && m_axis_tready;

    // acc * 10 + digit; digits 0 to 9 sit in the low nibble of their code.
    assign acc_times_ten = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                         + {31'd0, c[3:0]};

    always_comb
    begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        acc_next   = acc_reg;
        head_next  = head_reg;
        ovf_next   = ovf_reg;
        pend_valid = 1'b0;
        char_valid = 1'b0;
        pend_tok   = '0;
        char_tok   = '0;

        if (in_beat)
        begin
            if (mode_reg == MODE_IDENT && c_letter)
            begin
                if (len_reg < LEN_W'(MAX_TOKEN_LEN))
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        if (len_reg == LEN_W'(i))
                        begin
                            head_next[8*i +: 8] = c;
                        end
                    end
                    len_next = len_reg + LEN_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else if (mode_reg == MODE_INT && c_digit)
            begin
                if (acc_times_ten > {4'd0, INT_LIMIT})
                begin
                    acc_next = INT_LIMIT;
                    ovf_next = 1'b1;
                end
                else
                begin
                    acc_next = acc_times_ten[30:0];
                end
            end
            else
            begin
                // The pending token, if any, ends here.
                unique case (mode_reg)
                    MODE_INT:
                    begin
                        pend_valid        = 1'b1;
                        pend_tok.kind     = KIND_INT;
                        pend_tok.value    = acc_reg;
                        pend_tok.overflow = ovf_reg;
                    end
                    MODE_IDENT:
                    begin
                        pend_valid        = 1'b1;
                        if (len_reg == LEN_W'(3) && head_reg == KEYWORD_HEAD && !ovf_reg)
                        begin
                            pend_tok.kind = KIND_KEYWORD;
                        end
                        else
                        begin
                            pend_tok.kind = KIND_IDENT;
                        end
                        pend_tok.length   = 7'(len_reg);
                        pend_tok.head     = head_reg;
                        pend_tok.overflow = ovf_reg;
                    end
                    default:
                    begin
                        pend_valid = 1'b0;
                    end
                endcase

                mode_next = MODE_START;
                len_next  = '0;
                acc_next  = '0;
                head_next = '0;
                ovf_next  = 1'b0;

                // The character itself is then handled as fresh text.
                if (c == CHAR_EQUALS)
                begin
                    char_valid    = 1'b1;
                    char_tok.kind = KIND_EQUALS;
                end
                else if (c == CHAR_SEMI)
                begin
                    char_valid    = 1'b1;
                    char_tok.kind = KIND_SEMI;
                end
                else if (c_letter)
                begin
                    mode_next = MODE_IDENT;
                    len_next  = LEN_W'(1);
                    head_next = {56'd0, c};
                end
                else if (c_digit)
                begin
                    mode_next = MODE_INT;
                    acc_next  = {27'd0, c[3:0]};
                end
                else if (c != CHAR_NUL && !is_space(c))
                begin
                    char_valid    = 1'b1;
                    char_tok.kind = KIND_ERROR;
                end
            end
        end

        char_tok.last = 1'b1;
        pend_tok.last = !char_valid;
    end

    assign first_tok  = pend_valid ? pend_tok : char_tok;
    assign push_count = {1'b0, pend_valid} + {1'b0, char_valid};

    // New tokens land just behind the ones that stay after this cycle's pop.
    // A push only happens with at most two entries held, so the index fits.
    assign wr_idx = QPTR_W'(count_reg - QCNT_W'(out_beat));

    always_comb
    begin
        count_next = count_reg + QCNT_W'(push_count) - QCNT_W'(out_beat);
        q_next     = q_reg;
        if (out_beat)
        begin
            for (int i = 0; i < Q_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
        if (push_count != 2'd0)
        begin
            q_next[wr_idx] = first_tok;
        end
        if (push_count == 2'd2)
        begin
            q_next[wr_idx + QPTR_W'(1)] = char_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_START;
            len_reg    <= '0;
            acc_reg    <= '0;
            head_reg   <= '0;
            ovf_reg    <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            len_reg    <= len_next;
            acc_reg    <= acc_next;
            head_reg   <= head_next;
            ovf_reg    <= ovf_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign head_tok     = q_reg[0];
    assign m_axis_tdata = {1'b0, head_tok.overflow, head_tok.head,
                           head_tok.length, head_tok.value};
    assign m_axis_tuser = head_tok.kind;
    assign m_axis_tlast = head_tok.last;

endmodule

`default_nettype wire

FILE: tb/assignment_statement_tokenizer_tb.sv
// Self-checking testbench for the assignment statement tokenizer: characters go in on the
// slave stream and every token on the master stream is checked against a local tokenizer.
// Depends on ast_pkg and the assignment_statement_tokenizer RTL; reads and writes no files.
`timescale 1ns / 1ps

module assignment_statement_tokenizer_tb;

    import ast_pkg::*;

    localparam int NAME_MAX     = 64;       // longest identifier the block keeps
    localparam int RANDOM_CHARS = 1025;     // total characters, directed part included, at which the random part stops
    localparam int CYCLE_LIMIT  = 400000;   // generous bound on the whole run

    // Whitespace codes that the package does not name.
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUMBER, SCAN_NAME} scan_t;

    typedef enum logic [2:0] {
        CLS_LETTER, CLS_DIGIT, CLS_BLANK, CLS_EQUALS, CLS_SEMI, CLS_END, CLS_OTHER
    } char_cls_t;

    // Token scoreboard: it runs its own copy of the tokenizer on every accepted character,
    // keeps the tokens that character must produce, and checks each token leaving the block
    // against the oldest one waiting.
    class token_board;
        token_t      expect_q[$];
        scan_t       mode;
        logic [6:0]  count;
        logic [30:0] number;
        logic [63:0] head;
        logic        ovf;
        int          errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            mode   = SCAN_IDLE;
            count  = '0;
            number = '0;
            head   = '0;
            ovf    = 1'b0;
        endfunction

        function int pending();
            return expect_q.size();
        endfunction

        function char_cls_t classify(logic [7:0] c);
            if (c == CHAR_EQUALS)
                return CLS_EQUALS;
            if (c == CHAR_SEMI)
                return CLS_SEMI;
            if (c == CHAR_NUL)
                return CLS_END;
            if (c == CHAR_UNDERSCORE || (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
                    || (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z))
                return CLS_LETTER;
            if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
                return CLS_DIGIT;
            if (c == CHAR_SPACE || c == CHAR_TAB || c == CH_LF || c == CH_VT
                    || c == CH_FF || c == CHAR_CR)
                return CLS_BLANK;
            return CLS_OTHER;
        endfunction

        // The token that the word or number being scanned turns into when it ends.
        function token_t finished_token();
            token_t t;
            t = '0;
            t.overflow = ovf;
            if (mode == SCAN_NUMBER)
            begin
                t.kind  = KIND_INT;
                t.value = number;
            end
            else
            begin
                if (count == 7'd3 && head == KEYWORD_HEAD && !ovf)
                    t.kind = KIND_KEYWORD;
                else
                    t.kind = KIND_IDENT;
                t.length = count;
                t.head   = head;
            end
            return t;
        endfunction

        function token_t plain_token(token_kind_t kind);
            token_t t;
            t = '0;
            t.kind = kind;
            return t;
        endfunction

        // Works out the tokens that one accepted character causes, in order.
        function void note_char(logic [7:0] c);
            char_cls_t   cls;
            token_t      made[2];
            int          n;
            logic [34:0] wide;
            cls = classify(c);
            n = 0;
            // A letter extends a word; past the limit it is dropped and only flagged.
            if (mode == SCAN_NAME && cls == CLS_LETTER)
            begin
                if (count < 7'(NAME_MAX))
                begin
                    if (count < 7'd8)
                        head[8 * count +: 8] = c;
                    count++;
                end
                else
                begin
                    ovf = 1'b1;
                end
                return;
            end
            // A digit extends a number, which sticks at the largest value once it passes it.
            if (mode == SCAN_NUMBER && cls == CLS_DIGIT)
            begin
                wide = {4'd0, number} * 35'd10 + {27'd0, c - CHAR_DIGIT_0};
                if (wide > {4'd0, INT_LIMIT})
                begin
                    wide = {4'd0, INT_LIMIT};
                    ovf  = 1'b1;
                end
                number = wide[30:0];
                return;
            end
            // Anything else ends the pending token and is then taken on its own.
            if (mode != SCAN_IDLE)
            begin
                made[n] = finished_token();
                n++;
                clear();
            end
            case (cls)
                CLS_EQUALS:
                begin
                    made[n] = plain_token(KIND_EQUALS);
                    n++;
                end
                CLS_SEMI:
                begin
                    made[n] = plain_token(KIND_SEMI);
                    n++;
                end
                CLS_OTHER:
                begin
                    made[n] = plain_token(KIND_ERROR);
                    n++;
                end
                CLS_LETTER:
                begin
                    mode  = SCAN_NAME;
                    count = 7'd1;
                    head  = {56'd0, c};
                end
                CLS_DIGIT:
                begin
                    mode   = SCAN_NUMBER;
                    number = {23'd0, c - CHAR_DIGIT_0};
                end
                default: ;
            endcase
            for (int i = 0; i < n; i++)
            begin
                made[i].last = (i == n - 1);
                expect_q.push_back(made[i]);
            end
        endfunction

        function void compare(string what, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, what, want, got);
            end
        endfunction

        function void check_token(logic [103:0] data, logic [2:0] kind, logic last);
            token_t want;
            if (expect_q.size() == 0)
            begin
                errors++;
                $display("%0t: token of kind %0d with none expected, %s %0h",
                         $time, kind, "expected none, actual", data);
                return;
            end
            want = expect_q.pop_front();
            compare("token_kind", want.kind, kind);
            compare("token_value", want.value, data[30:0]);
            compare("ident_length", want.length, data[37:31]);
            compare("ident_head", want.head, data[101:38]);
            compare("overflow_flag", want.overflow, data[102]);
            compare("zero fill", 1'b0, data[103]);
            compare("last_of_run", want.last, last);
        endfunction
    endclass

    logic          clk;
    logic          rst_n         = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [7:0]    s_axis_tdata  = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [103:0]  m_axis_tdata;
    logic [2:0]    m_axis_tuser;
    logic          m_axis_tlast;

    token_board    board;
    int            burst_left    = 0;
    int            chars_sent    = 0;
    int            cycle_count   = 0;

    assignment_statement_tokenizer #(
        .MAX_TOKEN_LEN (NAME_MAX)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] char_code
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [30:0] token_value, [37:31] ident_length, [101:38] ident_head,
        // [102] overflow_flag, [103] zero fill
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),   // [2:0] token_kind
        .m_axis_tlast  (m_axis_tlast)    // last_of_run
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Any run that has not finished by the limit has hung somewhere.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Sends one character. The sender works in bursts; when a burst runs out it drops
    // tvalid for a random gap (sometimes none) and picks the length of the next burst,
    // now and then a long one so that stretches without idling occur as well.
    task automatic send_char(input logic [7:0] c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // The beat was taken at this edge.
        board.note_char(c);
        burst_left--;
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // A word of random letters and underscores; about one in ten is near the limit, often past it.
    task automatic send_name();
        int len;
        int pick;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(NAME_MAX - 4, NAME_MAX + 6)
                                          : $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 52);
            if (pick < 26)
                send_char(8'(CHAR_UPPER_A + pick));
            else if (pick < 52)
                send_char(8'(CHAR_LOWER_A + pick - 26));
            else
                send_char(CHAR_UNDERSCORE);
        end
    endtask

    // A decimal number: mostly short, sometimes long enough to saturate, and sometimes
    // right at the saturation boundary.
    task automatic send_number();
        int len;
        if ($urandom_range(0, 7) == 0)
        begin
            send_text("214748364");
            send_char(8'(CHAR_DIGIT_0 + $urandom_range(6, 9)));
        end
        else
        begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_char(8'(CHAR_DIGIT_0 + $urandom_range(0, 9)));
        end
    endtask

    // Up to 'most' whitespace characters of any of the six kinds; zero leaves tokens abutting.
    task automatic send_blank(input int most);
        int len;
        len = $urandom_range(0, most);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 5))
                0:       send_char(CHAR_SPACE);
                1:       send_char(CHAR_TAB);
                2:       send_char(CH_LF);
                3:       send_char(CH_VT);
                4:       send_char(CH_FF);
                default: send_char(CHAR_CR);
            endcase
        end
    endtask

    // The receiver changes its manner now and then: always ready, mostly ready, mostly
    // stalled, or a fixed on/off rhythm. Tokens are checked at the edge that takes them.
    int ready_mode = 0;
    int mode_left  = 0;
    int rhythm     = 0;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_token(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        if (mode_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 300);
        end
        else
        begin
            mode_left--;
        end
        rhythm = (rhythm == 4) ? 0 : rhythm + 1;
        case (ready_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (rhythm < 2);
        endcase
    end

    initial
    begin
        int  sel;
        bit  drained;
        board   = new();
        drained = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The keyword, all letter and digit extremes, and a statement.
        send_text("int _AZaz=09;");
        // A word cut short by unknown codes from the upper half of the byte range.
        send_text("x");
        send_char(8'h80);
        send_text("y");
        send_char(8'hFF);
        // A word ended by a digit, then a number ended by '=': two tokens from one beat.
        send_text("z9=");
        // The whitespace codes other than tab that the opening statement did not use.
        send_char(CH_VT);
        send_char(CH_FF);
        send_char(CH_LF);
        send_char(CHAR_CR);
        // End of text flushing a pending number, then again with nothing pending.
        send_text("7");
        send_char(CHAR_NUL);
        send_char(CHAR_NUL);

        // Random part: mostly well-formed statements and tokens with random content,
        // the rest random byte codes and end-of-text markers.
        while (chars_sent < RANDOM_CHARS)
        begin
            // Once, about half way, hold the input back until every token has come out.
            if (!drained && chars_sent > RANDOM_CHARS / 2)
            begin
                drained = 1'b1;
                s_axis_tvalid <= 1'b0;
                while (board.pending() != 0)
                    @(posedge clk);
                burst_left = 0;
            end
            sel = $urandom_range(0, 99);
            if (sel < 20)
            begin
                send_text("int");
                send_blank(2);
                send_name();
                send_blank(2);
                send_char(CHAR_EQUALS);
                send_blank(2);
                send_number();
                send_char(CHAR_SEMI);
                send_blank(3);
            end
            else if (sel < 40)
                send_name();
            else if (sel < 58)
                send_number();
            else if (sel < 66)
                send_char(CHAR_EQUALS);
            else if (sel < 74)
                send_char(CHAR_SEMI);
            else if (sel < 82)
                send_blank(3);
            else if (sel < 87)
                send_text(($urandom_range(0, 2) == 0) ? "in" : "int");
            else if (sel < 95)
                send_char(8'($urandom_range(0, 255)));
            else
                send_char(CHAR_NUL);
        end

        // Flush whatever is still being scanned, then let the result queue drain.
        send_char(CHAR_NUL);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
